[src/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// format codes, thresholds and the beat type shared by the converter stages
// ----------------------------------------------------------------------------
package pfc_pkg;

    typedef logic [3:0] t_fmt;

    localparam t_fmt FMT_RGBA32   = 4'd0;
    localparam t_fmt FMT_RBGA32   = 4'd1;
    localparam t_fmt FMT_GRBA32   = 4'd2;
    localparam t_fmt FMT_GBRA32   = 4'd3;
    localparam t_fmt FMT_BRGA32   = 4'd4;
    localparam t_fmt FMT_BGRA32   = 4'd5;
    localparam t_fmt FMT_MONO8    = 4'd6;
    localparam t_fmt FMT_MONO16   = 4'd7;
    localparam t_fmt FMT_MONO32   = 4'd8;
    localparam t_fmt FMT_MONO64   = 4'd9;
    localparam t_fmt FMT_R1G1B1I1 = 4'd10;
    localparam t_fmt FMT_R3G3B2   = 4'd11;
    localparam t_fmt FMT_ASCII    = 4'd12;
    localparam t_fmt FMT_VGA_CHAR = 4'd13;
    localparam t_fmt FMT_VGA_ATTR = 4'd14;
    localparam t_fmt FMT_INVALID  = 4'd15;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_INVALID = 2'd1;
    localparam t_status ST_NO_FMT  = 2'd2;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_SOURCE = 2'd0;
    localparam logic [1:0] CFG_DEST   = 2'd1;

    // intensity levels and character coverage colour
    localparam logic [7:0] LVL_FULL   = 8'hFF;
    localparam logic [7:0] LVL_HALF   = 8'h80;
    localparam logic [7:0] COVER_GREY = 8'hB0;
    localparam logic [7:0] CHAR_LO    = 8'h21;
    localparam logic [7:0] CHAR_HI    = 8'h7E;

    // thresholds
    localparam logic [7:0] TH_60 = 8'h60;
    localparam logic [7:0] TH_80 = 8'h80;
    localparam logic [7:0] TH_C0 = 8'hC0;
    localparam logic [7:0] TH_40 = 8'h40;
    localparam logic [7:0] TH_20 = 8'h20;
    localparam logic [7:0] TH_F0 = 8'hF0;
    localparam logic [7:0] TH_A0 = 8'hA0;

    // character ramp
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // divide by three: avg = (sum * 683) >> 11, exact for sum up to 765
    localparam logic [9:0] RECIP3 = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

    // one beat between stages
    typedef struct packed {
        logic        bypass;  // word is the final result
        logic [63:0] word;    // final result, or rgba in the low 32 bits
        t_status     status;
        t_fmt        dest;
        logic [7:0]  avg;
    } t_beat;

endpackage

[src/pfc_decode.sv]
// ----------------------------------------------------------------------------
// pfc_decode
// first stage: resolves the format pair and decodes the source pixel to rgba
// ----------------------------------------------------------------------------
module pfc_decode (
    input  logic          i_clk,
    input  logic          i_load,
    input  pfc_pkg::t_fmt i_src,
    input  pfc_pkg::t_fmt i_dest,
    input  logic [63:0]   i_pixel,
    output pfc_pkg::t_beat o_beat
);
    import pfc_pkg::*;

    t_beat r_beat;
    t_beat n_beat;

    function automatic logic [31:0] nibble_colour(input logic [3:0] nib);
        logic [7:0] lvl;
        lvl = nib[3] ? LVL_FULL : LVL_HALF;
        return {LVL_FULL, nib[2] ? lvl : 8'h00, nib[1] ? lvl : 8'h00,
                nib[0] ? lvl : 8'h00};
    endfunction

    function automatic logic [63:0] size_mask(input t_fmt f);
        case (f) inside
            FMT_MONO8, FMT_R1G1B1I1, FMT_R3G3B2, FMT_ASCII, FMT_VGA_CHAR,
            FMT_VGA_ATTR:                          return 64'h0000_0000_0000_00FF;
            FMT_MONO16:                            return 64'h0000_0000_0000_FFFF;
            [FMT_RGBA32:FMT_BGRA32], FMT_MONO32:   return 64'h0000_0000_FFFF_FFFF;
            FMT_MONO64:                            return 64'hFFFF_FFFF_FFFF_FFFF;
            default:                               return 64'h0;
        endcase
    endfunction

    logic [7:0]  b0, b1, b2, b3;
    logic [31:0] rgba;
    logic        src_ok;

    assign b0 = i_pixel[7:0];
    assign b1 = i_pixel[15:8];
    assign b2 = i_pixel[23:16];
    assign b3 = i_pixel[31:24];

    always_comb begin
        src_ok = 1'b1;
        case (i_src)
            FMT_RGBA32:   rgba = {b3, b2, b1, b0};
            FMT_RBGA32:   rgba = {b3, b1, b2, b0};
            FMT_GRBA32:   rgba = {b3, b2, b0, b1};
            FMT_GBRA32:   rgba = {b3, b1, b0, b2};
            FMT_BRGA32:   rgba = {b3, b0, b2, b1};
            FMT_BGRA32:   rgba = {b3, b0, b1, b2};
            FMT_R1G1B1I1: rgba = nibble_colour(b0[3:0]);
            FMT_VGA_ATTR: rgba = nibble_colour(b0[7:4]);
            FMT_ASCII, FMT_VGA_CHAR: begin
                rgba = (b0 >= CHAR_LO && b0 <= CHAR_HI) ?
                       {LVL_FULL, COVER_GREY, COVER_GREY, COVER_GREY} : 32'h0;
            end
            default: begin
                rgba   = 32'h0;
                src_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_beat.bypass = 1'b0;
        n_beat.word   = {32'h0, rgba};
        n_beat.status = ST_OK;
        n_beat.dest   = i_dest;
        n_beat.avg    = 8'h00;
        if (i_src == i_dest) begin
            // plain copy of the pixel's own bytes
            n_beat.bypass = 1'b1;
            n_beat.word   = i_pixel & size_mask(i_dest);
            n_beat.status = (i_dest == FMT_INVALID) ? ST_NO_FMT : ST_OK;
        end else if (i_src == FMT_RGBA32) begin
            n_beat.word = {32'h0, b3, b2, b1, b0};
            if (i_dest == FMT_INVALID) begin
                n_beat.bypass = 1'b1;
                n_beat.word   = 64'h0;
                n_beat.status = ST_NO_FMT;
            end
        end else if (!src_ok || i_dest == FMT_INVALID) begin
            n_beat.bypass = 1'b1;
            n_beat.word   = 64'h0;
            n_beat.status = ST_INVALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

[src/pfc_average.sv]
// ----------------------------------------------------------------------------
// pfc_average
// second stage: channel sum and divide by three through a reciprocal
// ----------------------------------------------------------------------------
module pfc_average (
    input  logic           i_clk,
    input  logic           i_load,
    input  pfc_pkg::t_beat i_beat,
    output pfc_pkg::t_beat o_beat
);
    import pfc_pkg::*;

    t_beat       r_beat;
    t_beat       n_beat;
    logic [9:0]  sum;
    logic [19:0] prod;

    assign sum  = {2'b00, i_beat.word[7:0]} + {2'b00, i_beat.word[15:8]}
                + {2'b00, i_beat.word[23:16]};
    assign prod = sum * RECIP3;

    always_comb begin
        n_beat     = i_beat;
        n_beat.avg = prod[RECIP3_SHIFT +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

[src/pfc_encode.sv]
// ----------------------------------------------------------------------------
// pfc_encode
// last stage: encodes rgba into the destination format, output register
// ----------------------------------------------------------------------------
module pfc_encode (
    input  logic             i_clk,
    input  logic             i_load,
    input  pfc_pkg::t_beat   i_beat,
    output logic [63:0]      o_pixel,
    output pfc_pkg::t_status o_status
);
    import pfc_pkg::*;

    logic [63:0] r_pixel;
    logic [63:0] n_pixel;
    t_status     r_status;

    logic [7:0] r, g, b, a, avg;
    logic [3:0] hi, lo;
    logic [7:0] ramp;

    assign r   = i_beat.word[7:0];
    assign g   = i_beat.word[15:8];
    assign b   = i_beat.word[23:16];
    assign a   = i_beat.word[31:24];
    assign avg = i_beat.avg;

    assign hi = {avg >= TH_F0, b >= TH_80, g >= TH_80, r >= TH_80};
    assign lo = {avg >= TH_A0, b >= TH_40, g >= TH_40, r >= TH_40};

    always_comb begin
        if (avg > TH_C0)      ramp = CH_AT;
        else if (avg > TH_80) ramp = CH_HASH;
        else if (avg > TH_40) ramp = CH_STAR;
        else if (avg > TH_20) ramp = CH_DOT;
        else                  ramp = CH_SPACE;
    end

    always_comb begin
        if (i_beat.bypass) begin
            n_pixel = i_beat.word;
        end else begin
            case (i_beat.dest)
                FMT_RGBA32:   n_pixel = {32'h0, a, b, g, r};
                FMT_RBGA32:   n_pixel = {32'h0, a, g, b, r};
                FMT_GRBA32:   n_pixel = {32'h0, a, b, r, g};
                FMT_GBRA32:   n_pixel = {32'h0, a, r, b, g};
                FMT_BRGA32:   n_pixel = {32'h0, a, g, r, b};
                FMT_BGRA32:   n_pixel = {32'h0, a, r, g, b};
                FMT_MONO8:    n_pixel = {56'h0, avg};
                FMT_MONO16:   n_pixel = {48'h0, avg, 8'h00};
                FMT_MONO32:   n_pixel = {32'h0, avg, 24'h0};
                FMT_MONO64:   n_pixel = {avg, 56'h0};
                FMT_R1G1B1I1: begin
                    n_pixel = {60'h0, avg >= TH_80, b >= TH_60, g >= TH_60, r >= TH_60};
                end
                FMT_R3G3B2:   n_pixel = {56'h0, b[7:6], g[7:5], r[7:5]};
                FMT_ASCII, FMT_VGA_CHAR: n_pixel = {56'h0, ramp};
                FMT_VGA_ATTR: n_pixel = {56'h0, hi, lo};
                default:      n_pixel = 64'h0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pixel  <= n_pixel;
            r_status <= i_beat.status;
        end
    end

    assign o_pixel  = r_pixel;
    assign o_status = r_status;

endmodule

[src/pixel_format_converter.sv]
// ----------------------------------------------------------------------------
// pixel_format_converter
// an accepted input beat passes the decode, average and encode registers
// throughput: one pixel per cycle while the output is not stalled; decode,
//   average and encode stages each hold one beat in a three-register pipeline
// reset: synchronous active low, clears stage valid bits and sets both
//   format registers to rgba32; no clearing pass, usable the cycle after
// ----------------------------------------------------------------------------
module pixel_format_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // pixel input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_pixel_in,

    // pixel output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_pixel_out,
    output logic [1:0]  o_conv_status,

    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import pfc_pkg::*;

    // format registers, written only while the pipeline is empty
    t_fmt r_src_fmt;
    t_fmt r_dest_fmt;

    // valid bits for the decode, average and encode/output registers
    logic r_v1, r_v2, r_v3;

    // a stage loads when it is empty or its content moves on
    logic adv1, adv2, adv3;

    t_beat   beat1;
    t_beat   beat2;
    t_status status3;

    assign adv3 = !r_v3 || !i_out_stall;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    // bubbles collapse, so input stalls only when every stage is full and held
    assign o_in_stall  = !adv1;
    // register beats wait until no pixel is left in the stages
    assign o_cfg_ready = !(r_v1 || r_v2 || r_v3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt  <= FMT_RGBA32;
            r_dest_fmt <= FMT_RGBA32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // indexes past the register list are dropped
            case (i_cfg_index)
                CFG_SOURCE: r_src_fmt  <= i_cfg_data;
                CFG_DEST:   r_dest_fmt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // stage one: format pair resolution and source decode
    pfc_decode u_decode (
        .i_clk   (i_clk),
        .i_load  (adv1 && i_in_valid),
        .i_src   (r_src_fmt),
        .i_dest  (r_dest_fmt),
        .i_pixel (i_pixel_in),
        .o_beat  (beat1)
    );

    // stage two: (r + g + b) / 3
    pfc_average u_average (
        .i_clk  (i_clk),
        .i_load (adv2 && r_v1),
        .i_beat (beat1),
        .o_beat (beat2)
    );

    // stage three: destination encode into the output register
    pfc_encode u_encode (
        .i_clk    (i_clk),
        .i_load   (adv3 && r_v2),
        .i_beat   (beat2),
        .o_pixel  (o_pixel_out),
        .o_status (status3)
    );

    assign o_out_valid   = r_v3;
    assign o_conv_status = status3;

endmodule

[dv/conversion_checker.sv]
// ----------------------------------------------------------------------------
// conversion_checker
// watches the pixel, result and register channels of the pixel format
// converter, predicts every result beat from its own copy of the format
// registers and compares it field by field, oldest prediction first
// ----------------------------------------------------------------------------
module conversion_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [63:0]       i_pixel_in,

    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [63:0]       i_pixel_out,
    input  pfc_pkg::t_status  i_conv_status,

    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  pfc_pkg::t_fmt     i_cfg_data,

    output int                o_mismatches,
    output int                o_waiting
);
    import pfc_pkg::*;

    typedef struct packed {
        logic [63:0] pixel;
        t_status     status;
    } t_conversion;

    t_fmt        src_fmt;
    t_fmt        dst_fmt;
    t_conversion expected_pixels[$];
    t_conversion head;

    function automatic logic [31:0] rgba_word(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    // one intensity nibble: bit 3 picks full or half level for r, g, b
    function automatic logic [31:0] nibble_rgba(input logic [3:0] nib);
        logic [7:0] lvl;
        lvl = nib[3] ? LVL_FULL : LVL_HALF;
        return rgba_word(nib[0] ? lvl : 8'h00, nib[1] ? lvl : 8'h00,
                         nib[2] ? lvl : 8'h00, LVL_FULL);
    endfunction

    function automatic logic decode_to_rgba(input t_fmt f, input logic [63:0] px,
                                            output logic [31:0] rgba);
        logic [7:0] b0, b1, b2, b3;
        b0 = px[7:0];
        b1 = px[15:8];
        b2 = px[23:16];
        b3 = px[31:24];
        rgba = '0;
        decode_to_rgba = 1'b1;
        case (f)
            FMT_RGBA32:   rgba = rgba_word(b0, b1, b2, b3);
            FMT_RBGA32:   rgba = rgba_word(b0, b2, b1, b3);
            FMT_GRBA32:   rgba = rgba_word(b1, b0, b2, b3);
            FMT_GBRA32:   rgba = rgba_word(b2, b0, b1, b3);
            FMT_BRGA32:   rgba = rgba_word(b1, b2, b0, b3);
            FMT_BGRA32:   rgba = rgba_word(b2, b1, b0, b3);
            FMT_R1G1B1I1: rgba = nibble_rgba(b0[3:0]);
            FMT_VGA_ATTR: rgba = nibble_rgba(b0[7:4]);
            FMT_ASCII, FMT_VGA_CHAR: begin
                if (b0 >= CHAR_LO && b0 <= CHAR_HI) begin
                    rgba = rgba_word(COVER_GREY, COVER_GREY, COVER_GREY, LVL_FULL);
                end
            end
            default: decode_to_rgba = 1'b0;
        endcase
    endfunction

    function automatic logic encode_from_rgba(input logic [31:0] rgba, input t_fmt f,
                                              output logic [63:0] word);
        logic [7:0] r, g, b, a, avg;
        logic [9:0] sum;
        r = rgba[7:0];
        g = rgba[15:8];
        b = rgba[23:16];
        a = rgba[31:24];
        sum = 10'(r) + 10'(g) + 10'(b);
        avg = 8'(sum / 10'd3);
        word = '0;
        encode_from_rgba = 1'b1;
        case (f)
            FMT_RGBA32:   word[31:0] = rgba;
            FMT_RBGA32:   word[31:0] = {a, g, b, r};
            FMT_GRBA32:   word[31:0] = {a, b, r, g};
            FMT_GBRA32:   word[31:0] = {a, r, b, g};
            FMT_BRGA32:   word[31:0] = {a, g, r, b};
            FMT_BGRA32:   word[31:0] = {a, r, g, b};
            FMT_MONO8:    word[7:0] = avg;
            FMT_MONO16:   word[15:8] = avg;
            FMT_MONO32:   word[31:24] = avg;
            FMT_MONO64:   word[63:56] = avg;
            FMT_R1G1B1I1: word[3:0] = {avg >= TH_80, b >= TH_60, g >= TH_60, r >= TH_60};
            FMT_R3G3B2:   word[7:0] = {b[7:6], g[7:5], r[7:5]};
            FMT_ASCII, FMT_VGA_CHAR: begin
                if (avg > TH_C0) word[7:0] = CH_AT;
                else if (avg > TH_80) word[7:0] = CH_HASH;
                else if (avg > TH_40) word[7:0] = CH_STAR;
                else if (avg > TH_20) word[7:0] = CH_DOT;
                else word[7:0] = CH_SPACE;
            end
            FMT_VGA_ATTR: begin
                word[7:0] = {avg >= TH_F0, b >= TH_80, g >= TH_80, r >= TH_80,
                             avg >= TH_A0, b >= TH_40, g >= TH_40, r >= TH_40};
            end
            default: encode_from_rgba = 1'b0;
        endcase
    endfunction

    function automatic logic [63:0] pixel_mask(input t_fmt f);
        case (f)
            FMT_MONO16: return 64'hFFFF;
            FMT_MONO64: return '1;
            FMT_RGBA32, FMT_RBGA32, FMT_GRBA32, FMT_GBRA32, FMT_BRGA32, FMT_BGRA32,
            FMT_MONO32: return 64'hFFFF_FFFF;
            default:    return 64'hFF;
        endcase
    endfunction

    function automatic t_conversion convert_pixel(input t_fmt src, input t_fmt dst,
                                                  input logic [63:0] px);
        t_conversion res;
        logic [31:0] rgba;
        logic [63:0] word;
        res.pixel = '0;
        res.status = ST_OK;
        if (src == dst) begin
            if (dst == FMT_INVALID) res.status = ST_NO_FMT;
            else res.pixel = px & pixel_mask(dst);
        end else if (dst == FMT_RGBA32) begin
            if (decode_to_rgba(src, px, rgba)) res.pixel = {32'h0, rgba};
            else res.status = ST_INVALID;
        end else if (src == FMT_RGBA32) begin
            if (encode_from_rgba(px[31:0], dst, word)) res.pixel = word;
            else res.status = ST_NO_FMT;
        end else begin
            if (!decode_to_rgba(src, px, rgba)) res.status = ST_INVALID;
            else if (!encode_from_rgba(rgba, dst, word)) res.status = ST_INVALID;
            else res.pixel = word;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            src_fmt <= FMT_RGBA32;
            dst_fmt <= FMT_RGBA32;
            expected_pixels.delete();
            o_mismatches <= 0;
            o_waiting <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SOURCE: src_fmt <= i_cfg_data;
                    CFG_DEST:   dst_fmt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_pixels.push_back(convert_pixel(src_fmt, dst_fmt, i_pixel_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_pixels.size() == 0) begin
                    if (o_mismatches < 10) begin
                        $display("conversion_checker: unexpected beat pixel %h status %0d",
                                 i_pixel_out, i_conv_status);
                    end
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    head = expected_pixels.pop_front();
                    if (head.pixel !== i_pixel_out || head.status !== i_conv_status) begin
                        if (o_mismatches < 10) begin
                            $display({"conversion_checker: pixel exp %h got %h, ",
                                      "status exp %0d got %0d"},
                                     head.pixel, i_pixel_out, head.status, i_conv_status);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            o_waiting <= expected_pixels.size();
        end
    end

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// drives the pixel format converter through every source and destination
// format pair with directed corner pixels and random pixels, with random
// gaps on the input side and random stalls on the output side; checking is
// done by conversion_checker beside the block
// ----------------------------------------------------------------------------
module tb;
    import pfc_pkg::*;

    // cycles without any beat on any channel before the run is given up
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last result, longer than the pass through the three stages
    localparam int DRAIN_CYCLES = 8;

    logic        clk;
    logic        rst_n;

    logic        in_valid;
    logic        in_stall;
    logic [63:0] pixel_in;

    logic        out_valid;
    logic        out_stall;
    logic [63:0] pixel_out;
    t_status     conv_status;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    t_fmt        cfg_data;

    int          mismatches;
    int          waiting;
    int          idle_cycles;

    // when set, neither side inserts gaps or stalls
    bit          quiet;

    pixel_format_converter dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_pixel_in    (pixel_in),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_out   (pixel_out),
        .o_conv_status (conv_status),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    conversion_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_pixel_in    (pixel_in),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_pixel_out   (pixel_out),
        .i_conv_status (conv_status),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_waiting     (waiting)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly none, often a few cycles, now and then a long one
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // byte values sitting on the thresholds and character coverage edges
    function automatic logic [7:0] corner_byte();
        case ($urandom_range(0, 10))
            0:       return 8'h00;
            1:       return TH_20;
            2:       return CHAR_LO;
            3:       return TH_40;
            4:       return TH_60;
            5:       return CHAR_HI;
            6:       return CHAR_HI + 8'd1;
            7:       return TH_80;
            8:       return TH_A0;
            9:       return TH_C0;
            default: return TH_F0;
        endcase
    endfunction

    // grey rgba pixel, so the average equals the level; upper word random
    function automatic logic [63:0] grey_pixel(input logic [7:0] lvl);
        return {$urandom(), LVL_FULL, lvl, lvl, lvl};
    endfunction

    function automatic logic [63:0] random_pixel();
        logic [63:0] base;
        logic [7:0]  lvl;
        base = {$urandom(), $urandom()};
        case ($urandom_range(0, 3))
            0: begin
                // grey just around a threshold, random alpha
                lvl = corner_byte() + 8'($urandom_range(0, 2)) - 8'd1;
                return {base[63:24], lvl, lvl, lvl};
            end
            1:       return {base[63:8], corner_byte()};
            default: return base;
        endcase
    endfunction

    // two register beats back to back; valid stays up between them
    task automatic set_formats(input t_fmt src, input t_fmt dst);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SOURCE;
        cfg_data  <= src;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_DEST;
        cfg_data  <= dst;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // one pixel beat, after an optional gap; valid is left high on return
    task automatic send_pixel(input logic [63:0] px);
        int gap;
        gap = quiet ? 0 : idle_len();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        do @(posedge clk); while (in_stall);
    endtask

    // close a phase: stop sending and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (waiting != 0);
    endtask

    // output side: stall bursts of random length, none while quiet
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            n = quiet ? 0 : idle_len();
            if (n == 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog: ends the run when no channel moves a beat for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n_pix;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        pixel_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SOURCE;
        cfg_data  = FMT_RGBA32;
        quiet     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---

        // reset formats rgba32 to rgba32: copy of the low four bytes only
        send_pixel('1);
        send_pixel('0);
        drain();

        // mono64 to mono64 keeps all eight bytes
        set_formats(FMT_MONO64, FMT_MONO64);
        send_pixel('1);
        drain();

        // both formats invalid
        set_formats(FMT_INVALID, FMT_INVALID);
        send_pixel({$urandom(), $urandom()});
        drain();

        // character coverage edges, upper bytes must not matter
        set_formats(FMT_ASCII, FMT_RGBA32);
        send_pixel({$urandom(), 8'($urandom_range(0, 255)), 8'h00, 8'h00, CHAR_LO - 8'd1});
        send_pixel({$urandom(), 8'($urandom_range(0, 255)), 8'hFF, 8'hFF, CHAR_LO});
        send_pixel({$urandom(), 8'($urandom_range(0, 255)), 8'h00, 8'hFF, CHAR_HI});
        send_pixel({$urandom(), 8'($urandom_range(0, 255)), 8'hFF, 8'h00, CHAR_HI + 8'd1});
        drain();

        // rgba32 source with invalid destination
        set_formats(FMT_RGBA32, FMT_INVALID);
        send_pixel('1);
        drain();

        // rgba32 destination from a source that cannot decode
        set_formats(FMT_MONO16, FMT_RGBA32);
        send_pixel('1);
        drain();

        // other failing pair
        set_formats(FMT_MONO8, FMT_VGA_ATTR);
        send_pixel('1);
        drain();

        // character ramp steps: one level on the lowest threshold, then each just past its threshold
        set_formats(FMT_RGBA32, FMT_ASCII);
        send_pixel(grey_pixel(TH_20));
        send_pixel(grey_pixel(TH_20 + 8'd1));
        send_pixel(grey_pixel(TH_40 + 8'd1));
        send_pixel(grey_pixel(TH_80 + 8'd1));
        send_pixel(grey_pixel(TH_C0 + 8'd1));
        drain();

        // attribute intensity bit on and just off
        set_formats(FMT_RGBA32, FMT_VGA_ATTR);
        send_pixel(grey_pixel(TH_F0));
        send_pixel(grey_pixel(TH_F0 - 8'd1));
        drain();

        // attribute high nibble and intensity nibble through rgba
        set_formats(FMT_VGA_ATTR, FMT_R1G1B1I1);
        send_pixel({$urandom(), 8'($urandom_range(0, 255)), 16'h0, 8'hF0});
        drain();
        set_formats(FMT_R1G1B1I1, FMT_R3G3B2);
        send_pixel({$urandom(), 8'($urandom_range(0, 255)), 16'h0, 8'h0F});
        drain();

        // --- random part: every source and destination pair in turn ---
        for (int s = 0; s < 16; s++) begin
            for (int d = 0; d < 16; d++) begin
                // about one phase in five runs with no gaps and no stalls
                quiet = ($urandom_range(0, 4) == 0);
                set_formats(t_fmt'(s), t_fmt'(d));
                n_pix = $urandom_range(4, 9);
                repeat (n_pix) send_pixel(random_pixel());
                drain();
            end
        end

        quiet = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && waiting == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
